>>> rtl/core/ffa_pkg.sv
// Shared types, constants and controller command codes for the first-fit allocator.
package ffa_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;

    localparam logic [15:0] HEADER_BYTES  = 16'd32;
    localparam logic [16:0] INITIAL_BYTES = 17'd1024;
    localparam logic [16:0] HEAP_SPAN     = 17'h10000;
    localparam logic [16:0] LIMIT_RESET   = 17'h10000;
    localparam logic [16:0] ADDR_MAX      = 17'h0FFFF;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_OOM      = 3'd1,
        STS_NULL     = 3'd2,
        STS_ALREADY  = 3'd3,
        STS_NOBLOCK  = 3'd4
    } status_t;

    typedef struct packed {
        logic        is_free;
        logic [15:0] bytes;
        logic [15:0] start;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_SET_RESULT,
        CMD_CREATE,
        CMD_SCAN_START,
        CMD_SCAN,
        CMD_GROW,
        CMD_GRANT,
        CMD_UP_START,
        CMD_UP,
        CMD_SPLIT_A,
        CMD_SPLIT_B,
        CMD_READ_NEXT,
        CMD_CAPTURE_NEXT,
        CMD_FREE_WRITE,
        CMD_DOWN,
        CMD_DROP,
        CMD_PUBLISH
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        status_t status;
    } ctl_cmd_t;

    typedef struct packed {
        logic is_free_op;
        logic null_addr;
        logic count_zero;
        logic create_ok;
        logic scan_hit;
        logic scan_miss;
        logic grow_ok;
        logic split_ok;
        logic block_free;
        logic walk_done;
        logic out_busy;
    } ctl_status_t;

endpackage

>>> rtl/core/ffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/ffa_datapath.sv
// Datapath: block table memory, heap registers, scan and shift walkers, result register.
module ffa_datapath import ffa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,
    input  logic        s_op,
    input  logic [15:0] s_req_size,
    input  logic [15:0] s_free_addr,
    input  logic        m_ready,
    input  ctl_cmd_t    cmd,
    output ctl_status_t sts,
    output logic        m_valid,
    output logic [2:0]  m_status,
    output logic [15:0] m_payload_addr
);

    logic [16:0]      limit_reg;
    logic [CNT_W-1:0] count_reg;
    logic [16:0]      top_reg;
    logic             op_reg;
    logic [15:0]      size_reg;
    logic [15:0]      faddr_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic             sv_reg;
    logic [IDX_W-1:0] chk_reg;
    logic [IDX_W-1:0] k_reg;
    entry_t           cur_reg;
    entry_t           prev_reg;
    logic             next_in_reg;
    logic             mnext_reg;
    logic [15:0]      nbytes_reg;
    logic [CNT_W-1:0] walk_reg;
    logic [1:0]       shift_r_reg;
    logic             dir_down_reg;
    logic             wv_reg;
    logic [IDX_W-1:0] wdst_reg;
    status_t          res_status_reg;
    logic [15:0]      res_addr_reg;
    logic             out_valid_reg;
    status_t          out_status_reg;
    logic [15:0]      out_addr_reg;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           rdata;

    logic [16:0]      bound;
    logic             scan_issue;
    logic             hit;
    logic [17:0]      grow_sum;
    logic [16:0]      top_hdr;
    logic             grow_ok;
    logic [15:0]      rest;
    logic             split_ok;
    logic             issue_up;
    logic             issue_down;
    logic [CNT_W:0]   down_src;
    logic             walk_done;
    logic             merge_prev;
    logic [15:0]      bytes_k;
    logic [15:0]      bytes_prev;
    logic [CNT_W:0]   k_plus1;

    ffa_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_BLOCKS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    always_comb begin
        bound      = (limit_reg > HEAP_SPAN) ? HEAP_SPAN : limit_reg;
        scan_issue = rd_idx_reg < count_reg;
        if (op_reg) begin
            hit = ({1'b0, rdata.start} + {1'b0, HEADER_BYTES}) == {1'b0, faddr_reg};
        end else begin
            hit = rdata.is_free && (rdata.bytes >= size_reg);
        end
        grow_sum   = {1'b0, top_reg} + {2'b0, HEADER_BYTES} + {2'b0, size_reg};
        top_hdr    = top_reg + {1'b0, HEADER_BYTES};
        grow_ok    = (count_reg < CNT_W'(MAX_BLOCKS)) && (grow_sum <= {1'b0, bound})
                     && (top_hdr <= ADDR_MAX);
        rest       = cur_reg.bytes - size_reg;
        split_ok   = (rest > HEADER_BYTES) && (count_reg < CNT_W'(MAX_BLOCKS));
        issue_up   = walk_reg > {1'b0, k_reg};
        down_src   = {1'b0, walk_reg} + {{(CNT_W-1){1'b0}}, shift_r_reg};
        issue_down = down_src < {1'b0, count_reg};
        walk_done  = !wv_reg && (dir_down_reg ? !issue_down : !issue_up);
        merge_prev = (k_reg != '0) && prev_reg.is_free;
        bytes_k    = mnext_reg ? (cur_reg.bytes + HEADER_BYTES + nbytes_reg) : cur_reg.bytes;
        bytes_prev = prev_reg.bytes + HEADER_BYTES + bytes_k;
        k_plus1    = {2'b0, k_reg} + (CNT_W+1)'(1);
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = k_reg;
        ram_wdata = cur_reg;
        ram_raddr = rd_idx_reg[IDX_W-1:0];
        unique case (cmd.op)
            CMD_CREATE: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{is_free: 1'b1,
                              bytes: INITIAL_BYTES[15:0] - HEADER_BYTES,
                              start: 16'd0};
            end
            CMD_GROW: begin
                ram_we    = 1'b1;
                ram_waddr = count_reg[IDX_W-1:0];
                ram_wdata = '{is_free: 1'b0, bytes: size_reg, start: top_reg[15:0]};
            end
            CMD_GRANT: begin
                ram_we    = 1'b1;
                ram_wdata = '{is_free: 1'b0, bytes: cur_reg.bytes, start: cur_reg.start};
            end
            CMD_UP: begin
                ram_raddr = walk_reg[IDX_W-1:0];
                ram_we    = wv_reg;
                ram_waddr = wdst_reg;
                ram_wdata = rdata;
            end
            CMD_SPLIT_A: begin
                ram_we    = 1'b1;
                ram_waddr = k_plus1[IDX_W-1:0];
                ram_wdata = '{is_free: 1'b1,
                              bytes: rest - HEADER_BYTES,
                              start: cur_reg.start + HEADER_BYTES + size_reg};
            end
            CMD_SPLIT_B: begin
                ram_we    = 1'b1;
                ram_wdata = '{is_free: 1'b0, bytes: size_reg, start: cur_reg.start};
            end
            CMD_READ_NEXT: begin
                ram_raddr = k_plus1[IDX_W-1:0];
            end
            CMD_FREE_WRITE: begin
                ram_we = 1'b1;
                if (merge_prev) begin
                    ram_waddr = k_reg - IDX_W'(1);
                    ram_wdata = '{is_free: 1'b1, bytes: bytes_prev, start: prev_reg.start};
                end else begin
                    ram_wdata = '{is_free: 1'b1, bytes: bytes_k, start: cur_reg.start};
                end
            end
            CMD_DOWN: begin
                ram_raddr = down_src[IDX_W-1:0];
                ram_we    = wv_reg;
                ram_waddr = wdst_reg;
                ram_wdata = rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= LIMIT_RESET;
            count_reg     <= '0;
            top_reg       <= '0;
            sv_reg        <= 1'b0;
            wv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (m_ready && cmd.op != CMD_PUBLISH) begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                CMD_LOAD: begin
                    op_reg    <= s_op;
                    size_reg  <= s_req_size;
                    faddr_reg <= s_free_addr;
                end
                CMD_SET_RESULT: begin
                    res_status_reg <= cmd.status;
                    res_addr_reg   <= '0;
                end
                CMD_CREATE: begin
                    count_reg <= CNT_W'(1);
                    top_reg   <= INITIAL_BYTES;
                end
                CMD_SCAN_START: begin
                    rd_idx_reg <= '0;
                    sv_reg     <= 1'b0;
                end
                CMD_SCAN: begin
                    if (scan_issue) begin
                        rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                    end
                    sv_reg  <= scan_issue;
                    chk_reg <= rd_idx_reg[IDX_W-1:0];
                    if (sv_reg) begin
                        if (hit) begin
                            cur_reg <= rdata;
                            k_reg   <= chk_reg;
                        end else begin
                            prev_reg <= rdata;
                        end
                    end
                end
                CMD_GROW: begin
                    count_reg      <= count_reg + CNT_W'(1);
                    top_reg        <= grow_sum[16:0];
                    res_status_reg <= STS_OK;
                    res_addr_reg   <= top_hdr[15:0];
                end
                CMD_GRANT, CMD_SPLIT_B: begin
                    res_status_reg <= STS_OK;
                    res_addr_reg   <= cur_reg.start + HEADER_BYTES;
                end
                CMD_UP_START: begin
                    walk_reg     <= count_reg - CNT_W'(1);
                    wv_reg       <= 1'b0;
                    dir_down_reg <= 1'b0;
                end
                CMD_UP: begin
                    if (issue_up) begin
                        walk_reg <= walk_reg - CNT_W'(1);
                    end
                    wv_reg   <= issue_up;
                    wdst_reg <= walk_reg[IDX_W-1:0] + IDX_W'(1);
                end
                CMD_SPLIT_A: begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                CMD_READ_NEXT: begin
                    next_in_reg <= k_plus1 < {1'b0, count_reg};
                end
                CMD_CAPTURE_NEXT: begin
                    mnext_reg  <= next_in_reg && rdata.is_free;
                    nbytes_reg <= rdata.bytes;
                end
                CMD_FREE_WRITE: begin
                    res_status_reg <= STS_OK;
                    res_addr_reg   <= '0;
                    wv_reg         <= 1'b0;
                    dir_down_reg   <= 1'b1;
                    if (merge_prev) begin
                        walk_reg    <= {1'b0, k_reg};
                        shift_r_reg <= 2'd1 + {1'b0, mnext_reg};
                    end else begin
                        walk_reg    <= k_plus1[CNT_W-1:0];
                        shift_r_reg <= {1'b0, mnext_reg};
                    end
                end
                CMD_DOWN: begin
                    if (issue_down) begin
                        walk_reg <= walk_reg + CNT_W'(1);
                    end
                    wv_reg   <= issue_down;
                    wdst_reg <= walk_reg[IDX_W-1:0];
                end
                CMD_DROP: begin
                    count_reg <= count_reg - {{(CNT_W-2){1'b0}}, shift_r_reg};
                end
                CMD_PUBLISH: begin
                    out_valid_reg  <= 1'b1;
                    out_status_reg <= res_status_reg;
                    out_addr_reg   <= res_addr_reg;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        sts.is_free_op = op_reg;
        sts.null_addr  = faddr_reg == 16'd0;
        sts.count_zero = count_reg == '0;
        sts.create_ok  = INITIAL_BYTES <= bound;
        sts.scan_hit   = sv_reg && hit;
        sts.scan_miss  = sv_reg && !hit && (chk_reg == count_reg[IDX_W-1:0] - IDX_W'(1));
        sts.grow_ok    = grow_ok;
        sts.split_ok   = split_ok;
        sts.block_free = cur_reg.is_free;
        sts.walk_done  = walk_done;
        sts.out_busy   = out_valid_reg && !m_ready;
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = out_status_reg;
    assign m_payload_addr = out_addr_reg;

endmodule

>>> rtl/core/ffa_controller.sv
// Controller: sequences each request through scan, grow, split and merge steps.
module ffa_controller import ffa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  ctl_status_t sts,
    output ctl_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_MISS,
        ST_AHIT,
        ST_SHIFT_UP,
        ST_SPLIT_B,
        ST_FHIT,
        ST_FNEXT,
        ST_FMERGE,
        ST_SHIFT_DOWN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd.op     = CMD_NOP;
        cmd.status = STS_OK;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = CMD_LOAD;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (sts.is_free_op) begin
                    if (sts.null_addr) begin
                        cmd.op     = CMD_SET_RESULT;
                        cmd.status = STS_NULL;
                        state_next = ST_DONE;
                    end else if (sts.count_zero) begin
                        cmd.op     = CMD_SET_RESULT;
                        cmd.status = STS_NOBLOCK;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN_INIT;
                    end
                end else if (sts.count_zero) begin
                    if (sts.create_ok) begin
                        cmd.op     = CMD_CREATE;
                        state_next = ST_SCAN_INIT;
                    end else begin
                        cmd.op     = CMD_SET_RESULT;
                        cmd.status = STS_OOM;
                        state_next = ST_DONE;
                    end
                end else begin
                    state_next = ST_SCAN_INIT;
                end
            end
            ST_SCAN_INIT: begin
                cmd.op     = CMD_SCAN_START;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.op = CMD_SCAN;
                if (sts.scan_hit) begin
                    state_next = sts.is_free_op ? ST_FHIT : ST_AHIT;
                end else if (sts.scan_miss) begin
                    if (sts.is_free_op) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_MISS;
                    end
                end
            end
            ST_MISS: begin
                if (sts.grow_ok) begin
                    cmd.op = CMD_GROW;
                end else begin
                    cmd.op     = CMD_SET_RESULT;
                    cmd.status = STS_OOM;
                end
                state_next = ST_DONE;
            end
            ST_AHIT: begin
                if (sts.split_ok) begin
                    cmd.op     = CMD_UP_START;
                    state_next = ST_SHIFT_UP;
                end else begin
                    cmd.op     = CMD_GRANT;
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT_UP: begin
                if (sts.walk_done) begin
                    cmd.op     = CMD_SPLIT_A;
                    state_next = ST_SPLIT_B;
                end else begin
                    cmd.op = CMD_UP;
                end
            end
            ST_SPLIT_B: begin
                cmd.op     = CMD_SPLIT_B;
                state_next = ST_DONE;
            end
            ST_FHIT: begin
                if (sts.block_free) begin
                    cmd.op     = CMD_SET_RESULT;
                    cmd.status = STS_ALREADY;
                    state_next = ST_DONE;
                end else begin
                    cmd.op     = CMD_READ_NEXT;
                    state_next = ST_FNEXT;
                end
            end
            ST_FNEXT: begin
                cmd.op     = CMD_CAPTURE_NEXT;
                state_next = ST_FMERGE;
            end
            ST_FMERGE: begin
                cmd.op     = CMD_FREE_WRITE;
                state_next = ST_SHIFT_DOWN;
            end
            ST_SHIFT_DOWN: begin
                if (sts.walk_done) begin
                    cmd.op     = CMD_DROP;
                    state_next = ST_DONE;
                end else begin
                    cmd.op = CMD_DOWN;
                end
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.op     = CMD_PUBLISH;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // A free that finds no block answers with a result set on the way out.
        if (state_reg == ST_SCAN && sts.is_free_op && !sts.scan_hit && sts.scan_miss) begin
            cmd.op     = CMD_SET_RESULT;
            cmd.status = STS_NOBLOCK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;

endmodule

>>> rtl/core/first_fit_heap_allocator_core.sv
// Top level of the first-fit heap allocator: controller plus datapath.
//
// Requests arrive on the s_ channel (valid/ready): s_op selects allocate (0) or
// free (1), with s_req_size or s_free_addr as operand. Each item yields one result
// on the m_ channel (valid/ready): m_status and m_payload_addr. The user must write
// the heap limit register (cfg_wr_en/cfg_wr_data) only while idle; not enforced.
//
// One item is processed at a time. From acceptance to m_valid an item passes
// through the control steps and the first-fit scan (one block table entry per
// cycle), plus a shift walk over the entries past the found one when a split
// inserts or a merge removes table entries. Scan and walk together cover the
// table about once.
//
// Reset empties the heap; the first allocate creates it. The result sits in an
// output register, so a new item is accepted while a result waits; if the
// receiver still stalls when the next result is ready, the block holds it.
module first_fit_heap_allocator_core import ffa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [15:0] s_req_size,
    input  logic [15:0] s_free_addr,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_payload_addr
);

    ctl_cmd_t    cmd;
    ctl_status_t sts;

    ffa_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ffa_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_op           (s_op),
        .s_req_size     (s_req_size),
        .s_free_addr    (s_free_addr),
        .m_ready        (m_ready),
        .cmd            (cmd),
        .sts            (sts),
        .m_valid        (m_valid),
        .m_status       (m_status),
        .m_payload_addr (m_payload_addr)
    );

endmodule
